// ===== design/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, constants and table builders for the power curve shaper.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Default build parameters
  localparam int SAMPLE_FRAC_BITS_DEF = 16;
  localparam int TABLE_ADDR_BITS_DEF  = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_SYMMETRY = 2'd0;
  localparam logic [1:0] REG_EXPONENT = 2'd1;

  // Symmetry mode codes
  typedef enum logic [1:0] {
    SYM_NONE  = 2'd0,
    SYM_AXIS  = 2'd1,
    SYM_POINT = 2'd2
  } pcs_sym_t;

  // Table entry widths: log in Q.24 up to 1.0, exp in Q.30 up to 1.0
  localparam int LOG_W = 25;
  localparam int EXP_W = 31;
  localparam int EXPK_W = 24;

  // Sideband that rides along with a sample through the power pipeline
  typedef struct packed {
    logic point;
    logic neg;
  } pcs_tag_t;

  typedef struct packed {
    logic     zero;
    logic     one;
    pcs_tag_t tag;
  } pcs_side_t;

  // Integer square root, elaboration only
  function automatic logic [63:0] pcs_isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/2^a) in Q.24 by repeated squaring
  function automatic logic [LOG_W-1:0] pcs_log_entry(input int i, input int a);
    logic [63:0] v;
    logic [63:0] y;
    v = (64'd1 << 30) + (64'(i) << (30 - a));
    y = 64'd0;
    if (i >= (1 << a)) return LOG_W'(1 << 24);
    for (int j = 1; j <= 24; j++) begin
      v = (v * v) >> 30;
      if (v >= (64'd2 << 30)) begin
        v = v >> 1;
        y = y | (64'd1 << (24 - j));
      end
    end
    return y[LOG_W-1:0];
  endfunction

  // 2^(-i/2^a) in Q.30 as a product of roots of one half
  function automatic logic [EXP_W-1:0] pcs_exp_entry(input int i, input int a);
    logic [63:0] roots [0:12];
    logic [63:0] p;
    for (int j = 0; j <= 12; j++) roots[j] = 64'd0;
    p = 64'd1 << 30;
    if (i >= (1 << a)) return EXP_W'(1 << 29);
    roots[1] = pcs_isqrt((64'd1 << 29) << 30);
    for (int j = 2; j <= a; j++) roots[j] = pcs_isqrt(roots[j-1] << 30);
    for (int j = 1; j <= a; j++) begin
      if (((i >> (a - j)) & 1) != 0) p = (p * roots[j]) >> 30;
    end
    return p[EXP_W-1:0];
  endfunction

endpackage

// ===== design/power_curve_shaper.sv =====
// ----------------------------------------------------------------------------
// power_curve_shaper
// Power-law transfer function on unsigned Q1.F samples with symmetry modes.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with sample_in to issue a request; busy is held low, so a
//   request is taken on every cycle that start is high.
//   Each request yields one result: done pulses for one cycle with
//   sample_out, in issue order. Throughput is one sample per clock: the
//   pipeline is twelve register stages (request capture, fold, nine power
//   stages from leading-one normalize through the rounding shift, symmetry
//   mix), each with its own valid bit.
//   The result has no back-pressure; the receiver must take done as given.
//   Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; ready is always
//   high. Index 0 is symmetry_mode, index 1 is exponent (Q8.16). Write only
//   while no request is in flight.
//   Reset (rst, synchronous) drops all in-flight requests and loads mode 0
//   and exponent 2.0.
// ----------------------------------------------------------------------------
module power_curve_shaper #(
  parameter int SAMPLE_FRAC_BITS = pcs_pkg::SAMPLE_FRAC_BITS_DEF,
  parameter int TABLE_ADDR_BITS  = pcs_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [SAMPLE_FRAC_BITS:0]  sample_in,
  output logic                       done,
  output logic [SAMPLE_FRAC_BITS:0]  sample_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [pcs_pkg::EXPK_W-1:0] cfg_data
);
  import pcs_pkg::*;

  localparam int F = SAMPLE_FRAC_BITS;
  localparam logic [F:0] ONE = (F+1)'(1) << F;
  localparam int LATENCY = 12;

  // Configuration registers
  logic [1:0]        symmetry_mode;
  logic [EXPK_W-1:0] exponent;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      symmetry_mode <= SYM_NONE;
      exponent      <= EXPK_W'(131072);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYMMETRY: symmetry_mode <= cfg_data[1:0];
        REG_EXPONENT: exponent      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request
  logic       in_vld;
  logic [F:0] in_x;

  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else     in_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    in_x <= sample_in;
  end

  // Clamp, and fold around one half in the axis and point symmetry modes
  logic [F:0]   xc;
  logic [F+1:0] x2;
  logic         fold;
  logic         neg;
  logic         fd_vld;
  logic [F:0]   fd_base;
  pcs_tag_t     fd_tag;

  always_comb begin
    xc   = (in_x > ONE) ? ONE : in_x;
    x2   = {xc, 1'b0};
    fold = (symmetry_mode == SYM_AXIS) || (symmetry_mode == SYM_POINT);
    neg  = x2 < (F+2)'(ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) fd_vld <= 1'b0;
    else     fd_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (!fold)    fd_base <= xc;
    else if (neg) fd_base <= (F+1)'((F+2)'(ONE) - x2);
    else          fd_base <= (F+1)'(x2 - (F+2)'(ONE));
    fd_tag <= '{point: (symmetry_mode == SYM_POINT), neg: neg};
  end

  // Power pipeline
  logic       pw_vld;
  logic [F:0] pw;
  pcs_tag_t   pw_tag;

  pcs_power #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
    .TABLE_ADDR_BITS  (TABLE_ADDR_BITS)
  ) u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fd_vld),
    .base      (fd_base),
    .in_tag    (fd_tag),
    .exponent  (exponent),
    .out_valid (pw_vld),
    .power     (pw),
    .out_tag   (pw_tag)
  );

  // Mix around one half for point symmetry and register the result
  logic [F+1:0] pt;

  always_comb begin
    if (pw_tag.neg) pt = ((F+2)'(ONE) - (F+2)'(pw) + 1'b1) >> 1;
    else            pt = ((F+2)'(ONE) + (F+2)'(pw) + 1'b1) >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= pw_vld;
  end

  always_ff @(posedge clk) begin
    if (pw_tag.point) sample_out <= (pt > (F+2)'(ONE)) ? ONE : pt[F:0];
    else              sample_out <= pw;
  end

`ifndef SYNTHESIS
  // Every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk)
    done |-> $past(start, LATENCY))
    else $error("result without matching request");

  // Results stay within full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> sample_out <= ONE)
    else $error("result above one");

  // Reset clears any pending result
  a_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result after reset");
`endif

endmodule

// ===== design/pcs_power.sv =====
// ----------------------------------------------------------------------------
// pcs_power
// Nine-stage pipeline forming b^k as exp2(-k * -log2 b) from two tables.
// ----------------------------------------------------------------------------
module pcs_power #(
  parameter int SAMPLE_FRAC_BITS = pcs_pkg::SAMPLE_FRAC_BITS_DEF,
  parameter int TABLE_ADDR_BITS  = pcs_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [SAMPLE_FRAC_BITS:0]   base,
  input  pcs_pkg::pcs_tag_t           in_tag,
  input  logic [pcs_pkg::EXPK_W-1:0]  exponent,
  output logic                        out_valid,
  output logic [SAMPLE_FRAC_BITS:0]   power,
  output pcs_pkg::pcs_tag_t           out_tag
);
  import pcs_pkg::*;

  localparam int F    = SAMPLE_FRAC_BITS;
  localparam int A    = TABLE_ADDR_BITS;
  localparam int N    = 1 << A;
  localparam int SH1  = 30 - A;
  localparam int SH2  = 24 - A;
  localparam int PB   = $clog2(F + 1);
  localparam int TW   = PB + 24;
  localparam int NW   = TW - 16;
  localparam int STG  = 9;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  // Constant tables
  logic [LOG_W-1:0] log_rom [0:N];
  logic [EXP_W-1:0] exp_rom [0:N];
  for (genvar g = 0; g <= N; g++) begin : g_rom
    assign log_rom[g] = pcs_log_entry(g, A);
    assign exp_rom[g] = pcs_exp_entry(g, A);
  end

  // Valid and sideband shift line
  logic      vld  [1:STG];
  pcs_side_t side [1:STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= STG; i++) vld[i] <= 1'b0;
    end else begin
      vld[1] <= in_valid;
      for (int i = 2; i <= STG; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side[1] <= '{zero: (base == '0), one: base[F], tag: in_tag};
    for (int i = 2; i <= STG; i++) side[i] <= side[i-1];
  end

  // Stage 1: find the leading one and normalize the mantissa
  logic [PB-1:0] lead;
  logic [30:0]   norm;
  logic [PB-1:0] s1_pos;
  logic [29:0]   s1_m;

  always_comb begin
    lead = '0;
    for (int i = 0; i < F; i++) begin
      if (base[i]) lead = PB'(i);
    end
    norm = 31'(base[F-1:0]) << (6'd30 - 6'(lead));
  end

  always_ff @(posedge clk) begin
    s1_pos <= PB'(F) - lead;
    s1_m   <= norm[29:0];
  end

  // Stage 2: read the log table around the mantissa
  logic [A:0]       lidx;
  logic [LOG_W-1:0] s2_lo, s2_hi;
  logic [SH1-1:0]   s2_fr;
  logic [PB-1:0]    s2_pos;

  assign lidx = {1'b0, s1_m[29 -: A]};

  always_ff @(posedge clk) begin
    s2_lo  <= log_rom[lidx];
    s2_hi  <= log_rom[lidx + 1'b1];
    s2_fr  <= s1_m[SH1-1:0];
    s2_pos <= s1_pos;
  end

  // Stage 3: weight both log entries
  logic [LOG_W+SH1:0] s3_plo, s3_phi;
  logic [PB-1:0]      s3_pos;

  always_ff @(posedge clk) begin
    s3_plo <= (LOG_W+SH1+1)'(s2_lo) * (LOG_W+SH1+1)'({1'b1, {SH1{1'b0}}} - {1'b0, s2_fr});
    s3_phi <= (LOG_W+SH1+1)'(s2_hi) * (LOG_W+SH1+1)'(s2_fr);
    s3_pos <= s2_pos;
  end

  // Stage 4: sum the log and form -log2 b
  logic [LOG_W+SH1+1:0] lsum;
  logic [TW-1:0]        s4_t;

  assign lsum = {1'b0, s3_plo} + {1'b0, s3_phi};

  always_ff @(posedge clk) begin
    s4_t <= (TW'(s3_pos) << 24) - TW'(lsum >> SH1);
  end

  // Stage 5: scale by the exponent
  logic [TW+EXPK_W-1:0] s5_prod;

  always_ff @(posedge clk) begin
    s5_prod <= (TW+EXPK_W)'(s4_t) * (TW+EXPK_W)'(exponent);
  end

  // Stage 6: split integer and fraction, read the exp table
  logic [NW-1:0]    nint;
  logic [23:0]      frac;
  logic [A:0]       eidx;
  logic [EXP_W-1:0] s6_lo, s6_hi;
  logic [SH2-1:0]   s6_fr;
  logic [5:0]       s6_n;
  logic             s6_ovf;

  assign nint = s5_prod[TW+EXPK_W-1 -: NW];
  assign frac = s5_prod[39:16];
  assign eidx = {1'b0, frac[23 -: A]};

  always_ff @(posedge clk) begin
    s6_lo  <= exp_rom[eidx];
    s6_hi  <= exp_rom[eidx + 1'b1];
    s6_fr  <= frac[SH2-1:0];
    s6_n   <= 6'(nint);
    s6_ovf <= (nint > NW'(32));
  end

  // Stage 7: weight both exp entries
  logic [EXP_W+SH2:0] s7_plo, s7_phi;
  logic [5:0]         s7_n;
  logic               s7_ovf;

  always_ff @(posedge clk) begin
    s7_plo <= (EXP_W+SH2+1)'(s6_lo) * (EXP_W+SH2+1)'({1'b1, {SH2{1'b0}}} - {1'b0, s6_fr});
    s7_phi <= (EXP_W+SH2+1)'(s6_hi) * (EXP_W+SH2+1)'(s6_fr);
    s7_n   <= s6_n;
    s7_ovf <= s6_ovf;
  end

  // Stage 8: sum the exp
  logic [EXP_W+SH2+1:0] esum;
  logic [EXP_W-1:0]     s8_e;
  logic [5:0]           s8_n;
  logic                 s8_ovf;

  assign esum = {1'b0, s7_plo} + {1'b0, s7_phi};

  always_ff @(posedge clk) begin
    s8_e   <= EXP_W'(esum >> SH2);
    s8_n   <= s7_n;
    s8_ovf <= s7_ovf;
  end

  // Stage 9: shift down with rounding, saturate, apply the edge cases
  logic [5:0]       amt;
  logic [EXP_W-1:0] wsh;
  logic [EXP_W-1:0] wr;
  logic [F:0]       sat;
  logic [F:0]       s9_pw;

  always_comb begin
    amt = 6'(29 - F) + s8_n;
    wsh = s8_e >> amt;
    wr  = (wsh + 1'b1) >> 1;
    sat = (wr > EXP_W'(ONE)) ? ONE : wr[F:0];
  end

  always_ff @(posedge clk) begin
    if (side[8].zero)      s9_pw <= '0;
    else if (side[8].one)  s9_pw <= ONE;
    else if (s8_ovf)       s9_pw <= '0;
    else                   s9_pw <= sat;
  end

  assign out_valid = vld[STG];
  assign power     = s9_pw;
  assign out_tag   = side[STG].tag;

`ifndef SYNTHESIS
  // A zero base never yields a nonzero power
  a_zero_base: assert property (@(posedge clk) disable iff (rst)
    vld[8] && side[8].zero |=> power == '0)
    else $error("zero base gave nonzero power");

  // Power never exceeds one
  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> power <= ONE)
    else $error("power above one");

  // A full-scale base gives exactly one
  a_one_base: assert property (@(posedge clk) disable iff (rst)
    vld[8] && side[8].one |=> power == ONE)
    else $error("full-scale base did not give one");
`endif

endmodule
